// ===== rtl/sorted_priority_queue_macros.svh =====
// Assertion macros for the sorted priority queue.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: assertion failed");

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types, constants and helper functions of the sorted priority queue.
// No dependencies; used by the interfaces, the controller and the top level.
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 16;
    localparam int PRIO_W      = 8;
    localparam int OCC_W       = 5;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_PULL   = 2'd1;
    localparam logic [1:0] CMD_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_HEAD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        t_entry            wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
    } t_result;

    // Ring buffer pointer arithmetic; the depth need not be a power of two.
    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] p);
        if (p == '0) begin
            return IDX_W'(QUEUE_DEPTH - 1);
        end
        return p - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] p);
        if (p == IDX_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
            s = s - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spq_if.sv =====
// Valid/ready channel interfaces for the command and result streams.
// Depends on spq_pkg for the field widths.
`default_nettype none

interface spq_in_if import spq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [TAG_W-1:0]  patient_tag;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, command, patient_tag, priority_req, input ready);
    modport sink (input valid, command, patient_tag, priority_req, output ready);
endinterface

interface spq_out_if import spq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [TAG_W-1:0]  head_tag;
    logic [PRIO_W-1:0] head_priority;
    logic [1:0]        status;
    logic [OCC_W-1:0]  occupancy;
    logic              empty_res;

    modport source (output valid, head_tag, head_priority, status, occupancy, empty_res,
                    input ready);
    modport sink (input valid, head_tag, head_priority, status, occupancy, empty_res,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_ram.sv =====
// Generic one-write, one-read memory with registered read data.
// No dependencies.
`default_nettype none

module spq_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [DATA_W-1:0]          i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output      logic [DATA_W-1:0]          o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/spq_ctrl.sv =====
// Sequencer of the sorted priority queue: ring pointers, occupancy and the
// insertion walk over the entry memory. Depends on spq_pkg.
`default_nettype none

module spq_ctrl import spq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire logic [1:0]        i_command,
    input  wire logic [TAG_W-1:0]  i_tag,
    input  wire logic [PRIO_W-1:0] i_prio,
    output      t_mem_req          o_mem,
    input  wire t_entry            i_rdata,
    output      t_result           o_res,
    input  wire logic              i_res_take
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_pull, n_pull;
    t_entry            r_item, n_item;
    logic [TAG_W-1:0]  r_res_tag, n_res_tag;
    logic [PRIO_W-1:0] r_res_prio, n_res_prio;
    logic [1:0]        r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_left     <= n_left;
        r_pull     <= n_pull;
        r_item     <= n_item;
        r_res_tag  <= n_res_tag;
        r_res_prio <= n_res_prio;
        r_status   <= n_status;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_head     = r_head;
        n_pos      = r_pos;
        n_left     = r_left;
        n_pull     = r_pull;
        n_item     = r_item;
        n_res_tag  = r_res_tag;
        n_res_prio = r_res_prio;
        n_status   = r_status;

        o_in_ready  = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_pos;
        o_mem.wdata = r_item;
        o_mem.raddr = r_head;

        o_res.valid  = 1'b0;
        o_res.tag    = r_res_tag;
        o_res.prio   = r_res_prio;
        o_res.status = r_status;
        o_res.count  = r_count;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item.tag  = i_tag;
                    n_item.prio = i_prio;
                    n_res_tag   = '0;
                    n_res_prio  = '0;
                    n_status    = ST_OK;
                    n_pull      = (i_command == CMD_PULL);
                    case (i_command)
                        CMD_INSERT: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                // Start the walk at the free slot behind the tail.
                                n_pos   = idx_add(r_head, r_count[IDX_W-1:0]);
                                n_left  = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_PULL, CMD_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                // The head read is issued this cycle.
                                n_state = S_HEAD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_left == '0) begin
                    n_state = S_INS_PUT;
                end else begin
                    o_mem.raddr = idx_prev(r_pos);
                    n_state     = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_mem.we = 1'b1;
                if (i_rdata.prio >= r_item.prio) begin
                    // Equal priorities stay ahead, so the new entry lands here.
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end else begin
                    // Move the lower entry one slot back and keep walking;
                    // the read of the next candidate overlaps this write.
                    o_mem.wdata = i_rdata;
                    n_pos       = idx_prev(r_pos);
                    n_left      = r_left - 1'b1;
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        o_mem.raddr = idx_prev(idx_prev(r_pos));
                    end
                end
            end
            S_INS_PUT: begin
                o_mem.we = 1'b1;
                n_count  = r_count + 1'b1;
                n_state  = S_DONE;
            end
            S_HEAD: begin
                n_res_tag  = i_rdata.tag;
                n_res_prio = i_rdata.prio;
                if (r_pull) begin
                    n_head  = idx_next(r_head);
                    n_count = r_count - 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res.valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue of QUEUE_DEPTH entries held in a ring-buffer memory in
// descending priority order; equal priorities leave in arrival order. Each
// command transfer yields exactly one result transfer. Commands are taken one
// at a time: an insert moves each lower-priority entry one slot back from the
// tail and writes the new one in the gap; a pull or peek reads the head; a
// rejected insert, an empty pull or peek and an unused command go straight
// to the result. The walk through the single-write, single-read entry memory
// sets the insert time. A finished result sits in an output register, so the
// next command is taken while it waits. No clearing pass runs after reset.
// Depends on spq_pkg, spq_if, spq_ram, spq_ctrl and the macro header.
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue import spq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_in_if.sink     i_cmd,
    spq_out_if.source  o_res
);

    t_mem_req w_mem;
    t_entry   w_rdata;
    t_result  w_done;
    logic     w_take;
    logic     w_in_ready;

    logic              r_out_valid;
    logic [TAG_W-1:0]  r_out_tag;
    logic [PRIO_W-1:0] r_out_prio;
    logic [1:0]        r_out_status;
    logic [CNT_W-1:0]  r_out_count;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_command  (i_cmd.command),
        .i_tag      (i_cmd.patient_tag),
        .i_prio     (i_cmd.priority_req),
        .o_mem      (w_mem),
        .i_rdata    (w_rdata),
        .o_res      (w_done),
        .i_res_take (w_take)
    );

    spq_ram #(
        .DATA_W ($bits(t_entry)),
        .DEPTH  (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    assign i_cmd.ready = w_in_ready;

    // The output register takes a new result when it is empty or being drained.
    assign w_take = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_done.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_done.valid) begin
            r_out_tag    <= w_done.tag;
            r_out_prio   <= w_done.prio;
            r_out_status <= w_done.status;
            r_out_count  <= w_done.count;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.head_tag      = r_out_tag;
    assign o_res.head_priority = r_out_prio;
    assign o_res.status        = r_out_status;
    assign o_res.occupancy     = OCC_W'(r_out_count);
    assign o_res.empty_res     = (r_out_count == '0);

    `SPQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, w_done.count <= CNT_W'(QUEUE_DEPTH))
    `SPQ_ASSERT_IMPL(a_full_means_full, i_clk, i_rst_n, w_done.valid && (w_done.status == ST_FULL), w_done.count == CNT_W'(QUEUE_DEPTH))
    `SPQ_ASSERT_IMPL(a_empty_means_empty, i_clk, i_rst_n, w_done.valid && (w_done.status == ST_EMPTY), w_done.count == '0)
    `SPQ_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_cmd.valid && w_in_ready, !w_in_ready)

endmodule

`default_nettype wire
